FILE: rtl/trsam_pkg.sv
// ----------------------------------------------------------------------------
// trsam_pkg
// Types and fixed-point constants for the TRS to affine matrix unit.
// ----------------------------------------------------------------------------
package trsam_pkg;

   localparam int QUAT_W = 16;          // Q1.14 quaternion component
   localparam int FIX_W  = 32;          // Q16.16 translation, scale, matrix entry
   localparam int QPROD_W = 2 * QUAT_W; // exact quaternion product, Q.28
   localparam int R28_W  = QPROD_W + 2; // rotation entry in Q.28, with headroom
   localparam int RSH    = 12;          // Q.28 -> Q.16
   localparam int ROT_W  = R28_W - RSH; // rotation entry in Q.16
   localparam int PROD_W = ROT_W + FIX_W; // entry times scale, Q.32
   localparam int PSH    = 16;          // Q.32 -> Q16.16
   localparam int NUM_ROT = 9;
   localparam int NUM_AX  = 3;

   localparam logic signed [R28_W-1:0]  ONE_Q28 = R28_W'(64'sd1 <<< 28);
   localparam logic signed [R28_W-1:0]  ROT_RND = R28_W'(64'sd1 <<< (RSH - 1));
   localparam logic signed [PROD_W-1:0] PROD_RND = PROD_W'(64'sd1 <<< (PSH - 1));
   localparam logic signed [FIX_W-1:0]  FIX_MAX = {1'b0, {(FIX_W-1){1'b1}}};
   localparam logic signed [FIX_W-1:0]  FIX_MIN = {1'b1, {(FIX_W-1){1'b0}}};

   typedef struct packed {
      logic signed [FIX_W-1:0]  trans_x;
      logic signed [FIX_W-1:0]  trans_y;
      logic signed [FIX_W-1:0]  trans_z;
      logic signed [QUAT_W-1:0] quat_w;
      logic signed [QUAT_W-1:0] quat_x;
      logic signed [QUAT_W-1:0] quat_y;
      logic signed [QUAT_W-1:0] quat_z;
      logic signed [FIX_W-1:0]  scale_x;
      logic signed [FIX_W-1:0]  scale_y;
      logic signed [FIX_W-1:0]  scale_z;
   } req_type;

   typedef struct packed {
      logic signed [FIX_W-1:0] m_r0c0;
      logic signed [FIX_W-1:0] m_r1c0;
      logic signed [FIX_W-1:0] m_r2c0;
      logic signed [FIX_W-1:0] m_r0c1;
      logic signed [FIX_W-1:0] m_r1c1;
      logic signed [FIX_W-1:0] m_r2c1;
      logic signed [FIX_W-1:0] m_r0c2;
      logic signed [FIX_W-1:0] m_r1c2;
      logic signed [FIX_W-1:0] m_r2c2;
      logic signed [FIX_W-1:0] m_r0c3;
      logic signed [FIX_W-1:0] m_r1c3;
      logic signed [FIX_W-1:0] m_r2c3;
   } rsp_type;

endpackage

FILE: rtl/trs_to_affine_matrix_unit.sv
// ----------------------------------------------------------------------------
// trs_to_affine_matrix_unit
// Translation, quaternion rotation and scale to the upper 3x4 affine matrix.
// ----------------------------------------------------------------------------
// Fully pipelined: one transform word enters per cycle unless the pipe is
// stalled; each word passes quaternion products, rotation entries rounded to
// Q.16, entry times scale multiply, then round and saturate into the output
// register. Each stage holds its word while the next stage is full, so back
// pressure on the result side stalls the pipe without losing or repeating a
// word. Rotation entries are not normalized; scaled entries round to nearest
// (ties up) and saturate to Q16.16; the translation column passes through.
module trs_to_affine_matrix_unit (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  trsam_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output trsam_pkg::rsp_type rsp_data
);

   // stage valid bits and per-stage ready
   logic s1_v_ff, s2_v_ff, s3_v_ff, s4_v_ff;
   logic s1_rdy, s2_rdy, s3_rdy, s4_rdy;

   assign s4_rdy    = !s4_v_ff || rsp_ready;
   assign s3_rdy    = !s3_v_ff || s4_rdy;
   assign s2_rdy    = !s2_v_ff || s3_rdy;
   assign s1_rdy    = !s1_v_ff || s2_rdy;
   assign req_ready = s1_rdy;
   assign rsp_valid = s4_v_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
         s3_v_ff <= 1'b0;
         s4_v_ff <= 1'b0;
      end else begin
         if (s1_rdy) s1_v_ff <= req_valid;
         if (s2_rdy) s2_v_ff <= s1_v_ff;
         if (s3_rdy) s3_v_ff <= s2_v_ff;
         if (s4_rdy) s4_v_ff <= s3_v_ff;
      end
   end

   // ---------------- stage 1: quaternion products (Q.28) ----------------
   logic signed [trsam_pkg::QPROD_W-1:0] xx_ff, yy_ff, zz_ff, xy_ff, xz_ff, yz_ff;
   logic signed [trsam_pkg::QPROD_W-1:0] wx_ff, wy_ff, wz_ff;
   logic signed [trsam_pkg::FIX_W-1:0]   s1_scale_ff [trsam_pkg::NUM_AX];
   logic signed [trsam_pkg::FIX_W-1:0]   s1_trans_ff [trsam_pkg::NUM_AX];

   always_ff @(posedge clock) begin
      if (s1_rdy) begin
         xx_ff <= trsam_pkg::QPROD_W'(req_data.quat_x) * trsam_pkg::QPROD_W'(req_data.quat_x);
         yy_ff <= trsam_pkg::QPROD_W'(req_data.quat_y) * trsam_pkg::QPROD_W'(req_data.quat_y);
         zz_ff <= trsam_pkg::QPROD_W'(req_data.quat_z) * trsam_pkg::QPROD_W'(req_data.quat_z);
         xy_ff <= trsam_pkg::QPROD_W'(req_data.quat_x) * trsam_pkg::QPROD_W'(req_data.quat_y);
         xz_ff <= trsam_pkg::QPROD_W'(req_data.quat_x) * trsam_pkg::QPROD_W'(req_data.quat_z);
         yz_ff <= trsam_pkg::QPROD_W'(req_data.quat_y) * trsam_pkg::QPROD_W'(req_data.quat_z);
         wx_ff <= trsam_pkg::QPROD_W'(req_data.quat_w) * trsam_pkg::QPROD_W'(req_data.quat_x);
         wy_ff <= trsam_pkg::QPROD_W'(req_data.quat_w) * trsam_pkg::QPROD_W'(req_data.quat_y);
         wz_ff <= trsam_pkg::QPROD_W'(req_data.quat_w) * trsam_pkg::QPROD_W'(req_data.quat_z);
         s1_scale_ff[0] <= req_data.scale_x;
         s1_scale_ff[1] <= req_data.scale_y;
         s1_scale_ff[2] <= req_data.scale_z;
         s1_trans_ff[0] <= req_data.trans_x;
         s1_trans_ff[1] <= req_data.trans_y;
         s1_trans_ff[2] <= req_data.trans_z;
      end
   end

   // ---------------- stage 2: rotation entries, rounded to Q.16 ----------------
   // entry index is column * 3 + row
   logic signed [trsam_pkg::R28_W-1:0] r28     [trsam_pkg::NUM_ROT];
   logic signed [trsam_pkg::R28_W-1:0] r28_rnd [trsam_pkg::NUM_ROT];
   logic signed [trsam_pkg::R28_W-1:0] e_xx, e_yy, e_zz, e_xy, e_xz, e_yz;
   logic signed [trsam_pkg::R28_W-1:0] e_wx, e_wy, e_wz;
   logic signed [trsam_pkg::ROT_W-1:0] rot_ff      [trsam_pkg::NUM_ROT];
   logic signed [trsam_pkg::FIX_W-1:0] s2_scale_ff [trsam_pkg::NUM_AX];
   logic signed [trsam_pkg::FIX_W-1:0] s2_trans_ff [trsam_pkg::NUM_AX];

   always_comb begin
      e_xx = trsam_pkg::R28_W'(xx_ff);
      e_yy = trsam_pkg::R28_W'(yy_ff);
      e_zz = trsam_pkg::R28_W'(zz_ff);
      e_xy = trsam_pkg::R28_W'(xy_ff);
      e_xz = trsam_pkg::R28_W'(xz_ff);
      e_yz = trsam_pkg::R28_W'(yz_ff);
      e_wx = trsam_pkg::R28_W'(wx_ff);
      e_wy = trsam_pkg::R28_W'(wy_ff);
      e_wz = trsam_pkg::R28_W'(wz_ff);
      r28[0] = trsam_pkg::ONE_Q28 - ((e_yy + e_zz) <<< 1);
      r28[1] = (e_xy + e_wz) <<< 1;
      r28[2] = (e_xz - e_wy) <<< 1;
      r28[3] = (e_xy - e_wz) <<< 1;
      r28[4] = trsam_pkg::ONE_Q28 - ((e_xx + e_zz) <<< 1);
      r28[5] = (e_yz + e_wx) <<< 1;
      r28[6] = (e_xz + e_wy) <<< 1;
      r28[7] = (e_yz - e_wx) <<< 1;
      r28[8] = trsam_pkg::ONE_Q28 - ((e_xx + e_yy) <<< 1);
      for (int k = 0; k < trsam_pkg::NUM_ROT; k++) begin
         r28_rnd[k] = r28[k] + trsam_pkg::ROT_RND;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_rdy) begin
         for (int k = 0; k < trsam_pkg::NUM_ROT; k++) begin
            // floor shift of the biased value: nearest, ties up
            rot_ff[k] <= r28_rnd[k][trsam_pkg::R28_W-1:trsam_pkg::RSH];
         end
         s2_scale_ff <= s1_scale_ff;
         s2_trans_ff <= s1_trans_ff;
      end
   end

   // ---------------- stage 3: entry times column scale (Q.32) ----------------
   logic signed [trsam_pkg::PROD_W-1:0] prod_ff     [trsam_pkg::NUM_ROT];
   logic signed [trsam_pkg::FIX_W-1:0]  s3_trans_ff [trsam_pkg::NUM_AX];

   always_ff @(posedge clock) begin
      if (s3_rdy) begin
         for (int k = 0; k < trsam_pkg::NUM_ROT; k++) begin
            prod_ff[k] <= trsam_pkg::PROD_W'(rot_ff[k])
                        * trsam_pkg::PROD_W'(s2_scale_ff[k / trsam_pkg::NUM_AX]);
         end
         s3_trans_ff <= s2_trans_ff;
      end
   end

   // ---------------- stage 4: round to Q16.16 and saturate ----------------
   localparam int HI_W = trsam_pkg::PROD_W - trsam_pkg::PSH - trsam_pkg::FIX_W + 1;

   logic signed [trsam_pkg::PROD_W-1:0] p_rnd [trsam_pkg::NUM_ROT];
   logic signed [trsam_pkg::FIX_W-1:0]  m_in  [trsam_pkg::NUM_ROT];
   logic signed [trsam_pkg::FIX_W-1:0]  m_ff  [trsam_pkg::NUM_ROT];
   logic signed [trsam_pkg::FIX_W-1:0]  s4_trans_ff [trsam_pkg::NUM_AX];
   logic [HI_W-1:0] hi_bits [trsam_pkg::NUM_ROT];

   always_comb begin
      for (int k = 0; k < trsam_pkg::NUM_ROT; k++) begin
         p_rnd[k]   = prod_ff[k] + trsam_pkg::PROD_RND;
         hi_bits[k] = p_rnd[k][trsam_pkg::PROD_W-1:trsam_pkg::PSH+trsam_pkg::FIX_W-1];
         // clamp when the bits above the result are not a plain sign extension
         if (hi_bits[k] == '0 || hi_bits[k] == '1) begin
            m_in[k] = p_rnd[k][trsam_pkg::PSH+trsam_pkg::FIX_W-1:trsam_pkg::PSH];
         end else if (p_rnd[k][trsam_pkg::PROD_W-1]) begin
            m_in[k] = trsam_pkg::FIX_MIN;
         end else begin
            m_in[k] = trsam_pkg::FIX_MAX;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s4_rdy) begin
         m_ff        <= m_in;
         s4_trans_ff <= s3_trans_ff;
      end
   end

   always_comb begin
      rsp_data.m_r0c0 = m_ff[0];
      rsp_data.m_r1c0 = m_ff[1];
      rsp_data.m_r2c0 = m_ff[2];
      rsp_data.m_r0c1 = m_ff[3];
      rsp_data.m_r1c1 = m_ff[4];
      rsp_data.m_r2c1 = m_ff[5];
      rsp_data.m_r0c2 = m_ff[6];
      rsp_data.m_r1c2 = m_ff[7];
      rsp_data.m_r2c2 = m_ff[8];
      rsp_data.m_r0c3 = s4_trans_ff[0];
      rsp_data.m_r1c3 = s4_trans_ff[1];
      rsp_data.m_r2c3 = s4_trans_ff[2];
   end

endmodule
